// ===== design/sliding_window_min_max_mean_core_defines.svh =====
// assertion macros for the sliding window min/max/mean block
// used by the checker file; no other dependencies
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SWMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SWMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/swmm_pkg.sv =====
// shared constants and types for the sliding window min/max/mean block
// no dependencies
package swmm_pkg;

  // default sizes
  localparam int unsigned SWMM_MAX_WINDOW   = 16;
  localparam int unsigned SWMM_SAMPLE_WIDTH = 16;

  // fixed field widths
  localparam int unsigned SWMM_WIN_LEN_W = 5;
  localparam int unsigned SWMM_COUNT_W   = 5;

  localparam logic [SWMM_WIN_LEN_W-1:0] SWMM_WIN_LEN_RESET = 5'd16;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } swmm_state_e;

  // control to each window cell
  typedef struct packed {
    logic shift;    // take the neighbor's sample
    logic live;     // this cell holds a live sample
  } swmm_cell_ctrl_t;

endpackage

// ===== design/swmm_sample_if.sv =====
// input item channel: one signed speed sample per item
// depends on swmm_pkg
interface swmm_sample_if import swmm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SWMM_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] speed_sample;

  modport source (output valid, output speed_sample, input ready);
  modport sink   (input valid, input speed_sample, output ready);
endinterface

// ===== design/swmm_result_if.sv =====
// result item channel: window min, max, mean and fill count
// depends on swmm_pkg
interface swmm_result_if import swmm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SWMM_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_min;
  logic signed [SAMPLE_WIDTH-1:0] window_max;
  logic signed [SAMPLE_WIDTH-1:0] window_mean;
  logic [SWMM_COUNT_W-1:0]        fill_count;

  modport source (output valid, output window_min, output window_max,
                  output window_mean, output fill_count, input ready);
  modport sink   (input valid, input window_min, input window_max,
                  input window_mean, input fill_count, output ready);
endinterface

// ===== design/swmm_cell.sv =====
// one window cell: holds a sample, shifts it to the older neighbor and
// folds it into the running min/max/sum passed along the chain; uses swmm_pkg
module swmm_cell import swmm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SWMM_SAMPLE_WIDTH,
  parameter int unsigned SUM_W        = SWMM_SAMPLE_WIDTH + 4
) (
  input  logic                           clk_i,
  input  swmm_cell_ctrl_t                ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o,
  input  logic signed [SAMPLE_WIDTH-1:0] min_i,
  input  logic signed [SAMPLE_WIDTH-1:0] max_i,
  input  logic signed [SUM_W-1:0]        sum_i,
  output logic signed [SAMPLE_WIDTH-1:0] min_o,
  output logic signed [SAMPLE_WIDTH-1:0] max_o,
  output logic signed [SUM_W-1:0]        sum_o
);

  logic signed [SAMPLE_WIDTH-1:0] sample_q, sample_d;
  logic signed [SAMPLE_WIDTH-1:0] min_q, min_d;
  logic signed [SAMPLE_WIDTH-1:0] max_q, max_d;
  logic signed [SUM_W-1:0]        sum_q, sum_d;

  // sample shift on push
  assign sample_d = ctrl_i.shift ? sample_i : sample_q;

  // fold own sample into the partial from the newer neighbor
  always_comb begin
    min_d = min_i;
    max_d = max_i;
    sum_d = sum_i;
    if (ctrl_i.live) begin
      if (sample_q < min_i) begin
        min_d = sample_q;
      end
      if (sample_q > max_i) begin
        max_d = sample_q;
      end
      sum_d = sum_i + SUM_W'(sample_q);
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    min_q    <= min_d;
    max_q    <= max_d;
    sum_q    <= sum_d;
  end

  assign sample_o = sample_q;
  assign min_o    = min_q;
  assign max_o    = max_q;
  assign sum_o    = sum_q;

endmodule

// ===== design/swmm_divider.sv =====
// serial signed divide of the window sum by the fill count, one quotient
// bit per cycle, truncating toward zero; uses swmm_pkg
module swmm_divider import swmm_pkg::*; #(
  parameter int unsigned SUM_W = SWMM_SAMPLE_WIDTH + 4,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned Q_W   = SWMM_SAMPLE_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [Q_W-1:0]   quotient_o
);

  localparam int unsigned ITER_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              neg_q, neg_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [SUM_W-1:0]  quo_signed;

  // one restoring step
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, div_q};
  assign ge     = (rem_sh >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      neg_d  = dividend_i[SUM_W-1];
      quo_d  = dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[SUM_W-2:0], ge};
      rem_d  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      iter_d = iter_q + ITER_W'(1);
      if (iter_q == ITER_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // restore the sign; magnitude never exceeds the sample range
  assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
  assign quotient_o = quo_signed[Q_W-1:0];
  assign done_o     = done_q;

endmodule

// ===== design/sliding_window_min_max_mean_core.sv =====
// Sliding window min/max/mean over signed speed samples. Each accepted item
// pushes one sample into a chain of MAX_WINDOW cells (newest in cell 0) and
// returns the lowest, highest and mean (truncated toward zero) of the held
// samples together with the fill count. One item is in work at a time: after
// the push the min/max/sum partials ripple through the cell chain, then a
// serial divider works out the mean one quotient bit per cycle, and only
// after the result is loaded is the next item accepted. A finished result
// waits in the output register while the next item is taken. window_len of 0
// acts as 1 and a value above MAX_WINDOW acts as MAX_WINDOW; shortening the
// window drops the oldest samples on the next push. Write window_len only
// while idle.
// Depends on swmm_pkg, swmm_sample_if, swmm_result_if, swmm_cell, swmm_divider.
module sliding_window_min_max_mean_core import swmm_pkg::*; #(
  parameter int unsigned MAX_WINDOW   = SWMM_MAX_WINDOW,
  parameter int unsigned SAMPLE_WIDTH = SWMM_SAMPLE_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      window_len_we_i,
  input  logic [SWMM_WIN_LEN_W-1:0] window_len_i,
  swmm_sample_if.sink               sample_if,
  swmm_result_if.source             result_if
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int unsigned CMP_W = (SWMM_WIN_LEN_W > CNT_W) ? SWMM_WIN_LEN_W : CNT_W;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_BOT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  swmm_state_e state_q, state_d;

  logic [SWMM_WIN_LEN_W-1:0] window_len_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          scan_cnt_q, scan_cnt_d;
  logic [CNT_W-1:0]          len_eff;
  logic [CNT_W-1:0]          keep;
  logic [CMP_W-1:0]          len_wide;
  logic                      in_accept;
  logic                      scan_done;
  logic                      div_start;
  logic                      div_done;
  logic signed [SAMPLE_WIDTH-1:0] div_quotient;
  logic                      out_load;
  logic                      out_valid_q, out_valid_d;

  logic signed [SAMPLE_WIDTH-1:0] out_min_q, out_max_q, out_mean_q;
  logic [SWMM_COUNT_W-1:0]        out_count_q;

  // cell chain links
  logic signed [SAMPLE_WIDTH-1:0] chain_sample [0:MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] chain_min    [0:MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] chain_max    [0:MAX_WINDOW];
  logic signed [SUM_W-1:0]        chain_sum    [0:MAX_WINDOW];

  assign in_accept       = sample_if.valid && sample_if.ready;
  assign sample_if.ready = (state_q == ST_IDLE);

  // window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= SWMM_WIN_LEN_RESET;
    end else if (window_len_we_i) begin
      window_len_q <= window_len_i;
    end
  end

  // effective length and samples kept across a push
  always_comb begin
    len_wide = CMP_W'(window_len_q);
    if (window_len_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (len_wide > CMP_W'(MAX_WINDOW)) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = len_wide[CNT_W-1:0];
    end
    keep = (count_q > (len_eff - CNT_W'(1))) ? (len_eff - CNT_W'(1)) : count_q;
  end

  // cell chain, newest sample enters at cell 0
  assign chain_sample[0] = sample_if.speed_sample;
  assign chain_min[0]    = SAMPLE_TOP;
  assign chain_max[0]    = SAMPLE_BOT;
  assign chain_sum[0]    = '0;

  for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
    swmm_cell_ctrl_t cell_ctrl;

    assign cell_ctrl.shift = in_accept;
    assign cell_ctrl.live  = (CNT_W'(gi) < count_q);

    swmm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .SUM_W        (SUM_W)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .sample_i (chain_sample[gi]),
      .sample_o (chain_sample[gi+1]),
      .min_i    (chain_min[gi]),
      .max_i    (chain_max[gi]),
      .sum_i    (chain_sum[gi]),
      .min_o    (chain_min[gi+1]),
      .max_o    (chain_max[gi+1]),
      .sum_o    (chain_sum[gi+1])
    );
  end

  // mean divider
  assign scan_done = (scan_cnt_q == CNT_W'(MAX_WINDOW));
  assign div_start = (state_q == ST_SCAN) && scan_done;

  swmm_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W),
    .Q_W   (SAMPLE_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (chain_sum[MAX_WINDOW]),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_cnt_d = scan_cnt_q;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          count_d    = keep + CNT_W'(1);
          scan_cnt_d = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_DIV;
        end else begin
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || result_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output item register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_min_q   <= chain_min[MAX_WINDOW];
      out_max_q   <= chain_max[MAX_WINDOW];
      out_mean_q  <= div_quotient;
      out_count_q <= SWMM_COUNT_W'(count_q);
    end
  end

  assign result_if.valid       = out_valid_q;
  assign result_if.window_min  = out_min_q;
  assign result_if.window_max  = out_max_q;
  assign result_if.window_mean = out_mean_q;
  assign result_if.fill_count  = out_count_q;

endmodule

// ===== design/swmm_checker.sv =====
// port-level checks for the sliding window min/max/mean block, bound to
// the top level; depends on swmm_pkg and the assertion macro header
`include "sliding_window_min_max_mean_core_defines.svh"

module swmm_checker import swmm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SWMM_SAMPLE_WIDTH
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] window_min_i,
  input logic signed [SAMPLE_WIDTH-1:0] window_max_i,
  input logic signed [SAMPLE_WIDTH-1:0] window_mean_i
);

  // lowest never above highest
  `SWMM_ASSERT_NOW(a_min_le_max, clk_i, rst_ni, out_valid_i, window_min_i <= window_max_i, "window min above window max")

  // mean lies between lowest and highest
  `SWMM_ASSERT_NOW(a_mean_in_range, clk_i, rst_ni, out_valid_i, (window_mean_i >= window_min_i) && (window_mean_i <= window_max_i), "window mean outside min..max")

  // one item in work at a time
  `SWMM_ASSERT_NEXT(a_one_in_work, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken on consecutive cycles")

  // a stalled result item holds
  `SWMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(window_min_i) && $stable(window_max_i) && $stable(window_mean_i), "stalled result item changed")

endmodule

bind sliding_window_min_max_mean_core swmm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swmm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (sample_if.valid),
  .in_ready_i    (sample_if.ready),
  .out_valid_i   (result_if.valid),
  .out_ready_i   (result_if.ready),
  .window_min_i  (result_if.window_min),
  .window_max_i  (result_if.window_max),
  .window_mean_i (result_if.window_mean)
);
